/* hw/rtl/mws_pkg.sv */
// Shared constants and types for the mecanum wheel speed solver.
// No dependencies; imported by every module of the block.
package mws_pkg;

   localparam int SPEED_WIDTH_DEF = 16;
   localparam int NUM_WHEELS      = 4;

   // Wheel lane positions
   localparam int WHEEL_ONE   = 0;
   localparam int WHEEL_TWO   = 1;
   localparam int WHEEL_THREE = 2;
   localparam int WHEEL_FOUR  = 3;

   // Per-transaction control that rides along the divider pipeline
   typedef struct packed {
      logic                  scale;
      logic [NUM_WHEELS-1:0] neg;
   } ctrl_type;

endpackage

/* hw/rtl/mws_kin_stage.sv */
// Kinematics front end: wheel sums (stage A), magnitudes and peak (stage B).
// Depends on mws_pkg.
module mws_kin_stage #(
   parameter int SPEED_WIDTH = mws_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic signed [SPEED_WIDTH-1:0]              in_forward,
   input  logic signed [SPEED_WIDTH-1:0]              in_side,
   input  logic signed [SPEED_WIDTH-1:0]              in_turn,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [mws_pkg::NUM_WHEELS-1:0]             out_neg,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] out_mag,
   output logic [SPEED_WIDTH:0]                       out_peak
);
   import mws_pkg::*;

   localparam int SW = SPEED_WIDTH + 2;

   logic [SW-1:0] fwd_x, side_x, turn_x;
   logic [NUM_WHEELS-1:0][SW-1:0] sum_in, sum_ff;
   logic a_valid_ff, a_valid_in, a_ready;

   logic [NUM_WHEELS-1:0]              neg_in, neg_ff;
   logic [NUM_WHEELS-1:0][SW-2:0]      mag_in, mag_ff;
   logic [SW-2:0]                      max01, max23, peak_in, peak_ff;
   logic b_valid_ff, b_valid_in, b_ready;

   // Stage A: exact sums with two bits of growth
   assign fwd_x  = {{2{in_forward[SPEED_WIDTH-1]}}, in_forward};
   assign side_x = {{2{in_side[SPEED_WIDTH-1]}}, in_side};
   assign turn_x = {{2{in_turn[SPEED_WIDTH-1]}}, in_turn};

   always_comb begin
      sum_in[WHEEL_ONE]   = fwd_x - side_x + turn_x;
      sum_in[WHEEL_TWO]   = turn_x - fwd_x - side_x;
      sum_in[WHEEL_THREE] = fwd_x + side_x + turn_x;
      sum_in[WHEEL_FOUR]  = turn_x - fwd_x + side_x;
   end

   assign a_ready    = !a_valid_ff || b_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign in_ready   = a_ready;

   // Stage B: magnitudes and the largest of them
   always_comb begin
      logic [SW-1:0] negated;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         negated   = -sum_ff[k];
         neg_in[k] = sum_ff[k][SW-1];
         mag_in[k] = neg_in[k] ? negated[SW-2:0] : sum_ff[k][SW-2:0];
      end
   end

   assign max01   = (mag_in[1] > mag_in[0]) ? mag_in[1] : mag_in[0];
   assign max23   = (mag_in[3] > mag_in[2]) ? mag_in[3] : mag_in[2];
   assign peak_in = (max23 > max01) ? max23 : max01;

   assign b_ready    = !b_valid_ff || out_ready;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         sum_ff <= sum_in;
      end
      if (a_valid_ff && b_ready) begin
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
         peak_ff <= peak_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;
   assign out_peak  = peak_ff;

endmodule

/* hw/rtl/mws_scale_stage.sv */
// Stage C: limit compare and magnitude * limit products, divider setup.
// Depends on mws_pkg.
module mws_scale_stage #(
   parameter int SPEED_WIDTH = mws_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [mws_pkg::NUM_WHEELS-1:0]                in_neg,
   input  logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] in_mag,
   input  logic [SPEED_WIDTH:0]                          in_peak,
   input  logic [SPEED_WIDTH-2:0]                        limit,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output mws_pkg::ctrl_type                             out_ctrl,
   output logic [SPEED_WIDTH:0]                          out_divisor,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0] out_rem,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] out_lq,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] out_mag
);
   import mws_pkg::*;

   localparam int PW = 2 * SPEED_WIDTH;

   ctrl_type ctrl_in, ctrl_ff;
   logic [SPEED_WIDTH:0] div_ff;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH:0]   rem_in, rem_ff;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH-2:0] lq_in, lq_ff, mag_ff;
   logic valid_ff, valid_in, ready;

   assign ctrl_in.scale = in_peak > {2'b00, limit};
   assign ctrl_in.neg   = in_neg;

   // Product is (W+1) x (W-1) bits; quotient bits are shifted in below it
   always_comb begin
      logic [PW-1:0] prod;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         prod      = PW'(in_mag[k]) * PW'(limit);
         rem_in[k] = prod[PW-1:SPEED_WIDTH-1];
         lq_in[k]  = prod[SPEED_WIDTH-2:0];
      end
   end

   assign ready    = !valid_ff || out_ready;
   assign valid_in = ready ? in_valid : valid_ff;
   assign in_ready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready) begin
         ctrl_ff <= ctrl_in;
         div_ff  <= in_peak;
         rem_ff  <= rem_in;
         lq_ff   <= lq_in;
         for (int k = 0; k < NUM_WHEELS; k++) begin
            mag_ff[k] <= in_mag[k][SPEED_WIDTH-2:0];
         end
      end
   end

   assign out_valid   = valid_ff;
   assign out_ctrl    = ctrl_ff;
   assign out_divisor = div_ff;
   assign out_rem     = rem_ff;
   assign out_lq      = lq_ff;
   assign out_mag     = mag_ff;

endmodule

/* hw/rtl/mws_div_step.sv */
// One restoring-division stage: one quotient bit for each of the four lanes.
// Depends on mws_pkg.
module mws_div_step #(
   parameter int SPEED_WIDTH = mws_pkg::SPEED_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  mws_pkg::ctrl_type                               in_ctrl,
   input  logic [SPEED_WIDTH:0]                            in_divisor,
   input  logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0]   in_rem,
   input  logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] in_lq,
   input  logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] in_mag,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output mws_pkg::ctrl_type                               out_ctrl,
   output logic [SPEED_WIDTH:0]                            out_divisor,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH:0]   out_rem,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] out_lq,
   output logic [mws_pkg::NUM_WHEELS-1:0][SPEED_WIDTH-2:0] out_mag
);
   import mws_pkg::*;

   ctrl_type ctrl_ff;
   logic [SPEED_WIDTH:0] div_ff;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH:0]   rem_in, rem_ff;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH-2:0] lq_in, lq_ff, mag_ff;
   logic valid_ff, valid_in, ready;

   // Shift in the next dividend bit, subtract the divisor if it fits.
   // lq holds the unused dividend bits on top and quotient bits below.
   always_comb begin
      logic [SPEED_WIDTH+1:0] shifted;
      logic [SPEED_WIDTH+2:0] diff;
      logic                   fits;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         shifted   = {in_rem[k], in_lq[k][SPEED_WIDTH-2]};
         diff      = {1'b0, shifted} - {2'b00, in_divisor};
         fits      = !diff[SPEED_WIDTH+2];
         rem_in[k] = fits ? diff[SPEED_WIDTH:0] : shifted[SPEED_WIDTH:0];
         lq_in[k]  = {in_lq[k][SPEED_WIDTH-3:0], fits};
      end
   end

   assign ready    = !valid_ff || out_ready;
   assign valid_in = ready ? in_valid : valid_ff;
   assign in_ready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready) begin
         ctrl_ff <= in_ctrl;
         div_ff  <= in_divisor;
         rem_ff  <= rem_in;
         lq_ff   <= lq_in;
         mag_ff  <= in_mag;
      end
   end

   assign out_valid   = valid_ff;
   assign out_ctrl    = ctrl_ff;
   assign out_divisor = div_ff;
   assign out_rem     = rem_ff;
   assign out_lq      = lq_ff;
   assign out_mag     = mag_ff;

endmodule

/* hw/rtl/mecanum_wheel_speed_solver.sv */
// Top level of the mecanum wheel speed solver: config register, pipeline, output.
// Depends on mws_pkg, mws_kin_stage, mws_scale_stage, mws_div_step.
//
// Usage:
//  - req_ channel: one chassis command (forward, side, turn; signed Q8.8) per
//    transaction, taken when req_valid is high and req_stall is low.
//  - rsp_ channel: four wheel speeds plus was_scaled, delivered when rsp_valid
//    is high and rsp_stall is low. Exactly one response per request, in order.
//  - csr_ channel: writes the wheel speed limit (always ready). Write it only
//    while no transaction is in flight.
//  - Registered stages from acceptance to rsp_valid, in order: sums, peak,
//    multiply, SPEED_WIDTH-1 divider steps, output register.
//  - Throughput: one transaction per cycle unless stalled. The divider is a chain
//    of SPEED_WIDTH-1 restoring stages, one quotient bit per stage, four lanes.
//  - Each stage has its own valid bit and loads whenever it is empty or its
//    successor moves, so bubbles close up while rsp_stall is held; req_stall
//    rises only once every stage is full.
//  - Reset (synchronous) empties the pipeline and sets the limit to its
//    all-ones value; no clearing pass is needed.
module mecanum_wheel_speed_solver #(
   parameter int SPEED_WIDTH = mws_pkg::SPEED_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SPEED_WIDTH-1:0] req_forward_speed,
   input  logic signed [SPEED_WIDTH-1:0] req_side_speed,
   input  logic signed [SPEED_WIDTH-1:0] req_turn_speed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SPEED_WIDTH-1:0] rsp_wheel_one,
   output logic signed [SPEED_WIDTH-1:0] rsp_wheel_two,
   output logic signed [SPEED_WIDTH-1:0] rsp_wheel_three,
   output logic signed [SPEED_WIDTH-1:0] rsp_wheel_four,
   output logic                          rsp_was_scaled,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [SPEED_WIDTH-2:0]        csr_wheel_speed_limit
);
   import mws_pkg::*;

   localparam int NSTEP = SPEED_WIDTH - 1;   // one divider stage per quotient bit

   // Speed limit register
   logic [SPEED_WIDTH-2:0] limit_ff;

   // Front end to stage C
   logic kin_ready, kin_valid, scale_ready;
   logic [NUM_WHEELS-1:0]                kin_neg;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH:0] kin_mag;
   logic [SPEED_WIDTH:0]                 kin_peak;

   // Divider chain nodes: node 0 is stage C output, node NSTEP the last step
   logic [NSTEP:0]                         node_valid, node_ready;
   ctrl_type                               node_ctrl [NSTEP+1];
   logic [SPEED_WIDTH:0]                   node_div  [NSTEP+1];
   logic [NUM_WHEELS-1:0][SPEED_WIDTH:0]   node_rem  [NSTEP+1];
   logic [NUM_WHEELS-1:0][SPEED_WIDTH-2:0] node_lq   [NSTEP+1];
   logic [NUM_WHEELS-1:0][SPEED_WIDTH-2:0] node_mag  [NSTEP+1];

   // Output register
   logic                                   rsp_valid_ff, rsp_valid_in, out_adv;
   logic                                   scaled_ff;
   logic [NUM_WHEELS-1:0][SPEED_WIDTH-1:0] wheel_in, wheel_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_wheel_speed_limit;
      end
   end

   // ---------------------------------------------------------------- stages A, B
   mws_kin_stage #(.SPEED_WIDTH(SPEED_WIDTH)) u_kin (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (kin_ready),
      .in_forward (req_forward_speed),
      .in_side    (req_side_speed),
      .in_turn    (req_turn_speed),
      .out_valid  (kin_valid),
      .out_ready  (scale_ready),
      .out_neg    (kin_neg),
      .out_mag    (kin_mag),
      .out_peak   (kin_peak)
   );

   assign req_stall = !kin_ready;

   // ---------------------------------------------------------------- stage C
   mws_scale_stage #(.SPEED_WIDTH(SPEED_WIDTH)) u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (kin_valid),
      .in_ready    (scale_ready),
      .in_neg      (kin_neg),
      .in_mag      (kin_mag),
      .in_peak     (kin_peak),
      .limit       (limit_ff),
      .out_valid   (node_valid[0]),
      .out_ready   (node_ready[0]),
      .out_ctrl    (node_ctrl[0]),
      .out_divisor (node_div[0]),
      .out_rem     (node_rem[0]),
      .out_lq      (node_lq[0]),
      .out_mag     (node_mag[0])
   );

   // ---------------------------------------------------------------- divider
   for (genvar i = 0; i < NSTEP; i++) begin : g_div
      mws_div_step #(.SPEED_WIDTH(SPEED_WIDTH)) u_step (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (node_valid[i]),
         .in_ready    (node_ready[i]),
         .in_ctrl     (node_ctrl[i]),
         .in_divisor  (node_div[i]),
         .in_rem      (node_rem[i]),
         .in_lq       (node_lq[i]),
         .in_mag      (node_mag[i]),
         .out_valid   (node_valid[i+1]),
         .out_ready   (node_ready[i+1]),
         .out_ctrl    (node_ctrl[i+1]),
         .out_divisor (node_div[i+1]),
         .out_rem     (node_rem[i+1]),
         .out_lq      (node_lq[i+1]),
         .out_mag     (node_mag[i+1])
      );
   end

   // ---------------------------------------------------------------- output
   // Scaled: quotient magnitude; unscaled: the sum magnitude (at most the limit).
   always_comb begin
      logic [SPEED_WIDTH-2:0] mag_sel;
      logic [SPEED_WIDTH-1:0] mag_ext;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         mag_sel     = node_ctrl[NSTEP].scale ? node_lq[NSTEP][k] : node_mag[NSTEP][k];
         mag_ext     = {1'b0, mag_sel};
         wheel_in[k] = node_ctrl[NSTEP].neg[k] ? -mag_ext : mag_ext;
      end
   end

   assign out_adv           = !rsp_valid_ff || !rsp_stall;
   assign node_ready[NSTEP] = out_adv;
   assign rsp_valid_in      = out_adv ? node_valid[NSTEP] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (node_valid[NSTEP] && out_adv) begin
         wheel_ff  <= wheel_in;
         scaled_ff <= node_ctrl[NSTEP].scale;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_one   = wheel_ff[WHEEL_ONE];
   assign rsp_wheel_two   = wheel_ff[WHEEL_TWO];
   assign rsp_wheel_three = wheel_ff[WHEEL_THREE];
   assign rsp_wheel_four  = wheel_ff[WHEEL_FOUR];
   assign rsp_was_scaled  = scaled_ff;

`ifndef NO_ASSERTIONS
   localparam logic [SPEED_WIDTH-1:0] MOST_NEG = {1'b1, {(SPEED_WIDTH-1){1'b0}}};

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Final remainder stays below the divisor whenever scaling applied
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      node_valid[NSTEP] && node_ctrl[NSTEP].scale |->
         node_rem[NSTEP][WHEEL_ONE] < node_div[NSTEP] &&
         node_rem[NSTEP][WHEEL_TWO] < node_div[NSTEP] &&
         node_rem[NSTEP][WHEEL_THREE] < node_div[NSTEP] &&
         node_rem[NSTEP][WHEEL_FOUR] < node_div[NSTEP])
      else $error("divider remainder not below divisor");

   // Last divider stage keeps its transaction while the output is blocked
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      node_valid[NSTEP] && !out_adv |=> node_valid[NSTEP])
      else $error("divider output dropped under stall");

   // Wheel magnitudes never exceed the limit width, so the most negative code
   // cannot appear
   a_no_most_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_wheel_one != MOST_NEG && rsp_wheel_two != MOST_NEG &&
         rsp_wheel_three != MOST_NEG && rsp_wheel_four != MOST_NEG)
      else $error("wheel output at most negative code");
`endif

endmodule
